### sv/q16_16_arithmetic_unit_defines.svh
// Assertion macros used by the checker of the arithmetic unit.
`ifndef Q16_16_ARITHMETIC_UNIT_DEFINES_SVH
`define Q16_16_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Q16AU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("q16au assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define Q16AU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("q16au assertion failed");

`endif

### sv/q16au_pkg.sv
package q16au_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIV_W     = DATA_W + FRAC_BITS;

    localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic signed [2*DATA_W-1:0] ROUND_HALF =
        (2*DATA_W)'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [2*DATA_W-1:0] MAX_WIDE = (2*DATA_W)'($signed(MAX_VAL));
    localparam logic signed [2*DATA_W-1:0] MIN_WIDE = (2*DATA_W)'($signed(MIN_VAL));

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SADD = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4
    } action_t;

    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic              dz;
        logic [DATA_W-1:0] result;
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] rem;
        logic [DIV_W-1:0]  num;
    } cell_t;

endpackage

### sv/q16au_front.sv
module q16au_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic [2:0]                            in_action,
    input  logic signed [q16au_pkg::DATA_W-1:0]   in_left,
    input  logic signed [q16au_pkg::DATA_W-1:0]   in_right,
    output logic                                  out_valid,
    output q16au_pkg::cell_t                      out_item
);

    logic                                    v1_reg;
    logic [2:0]                              op1_reg;
    logic signed [q16au_pkg::DATA_W-1:0]     a1_reg;
    logic signed [q16au_pkg::DATA_W-1:0]     b1_reg;
    logic signed [2*q16au_pkg::DATA_W-1:0]   prod1_reg;

    logic                                    v2_reg;
    q16au_pkg::cell_t                        item2_reg;
    q16au_pkg::cell_t                        item2_next;

    logic signed [q16au_pkg::DATA_W:0]       sum_w;
    logic [q16au_pkg::DATA_W-1:0]            sadd_val;
    logic signed [2*q16au_pkg::DATA_W-1:0]   mul_round;
    logic signed [2*q16au_pkg::DATA_W-1:0]   mul_shift;
    logic [q16au_pkg::DATA_W-1:0]            mul_val;
    logic [q16au_pkg::DATA_W-1:0]            abs_a;
    logic [q16au_pkg::DATA_W-1:0]            abs_b;
    logic                                    b_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg   <= in_action;
            a1_reg    <= in_left;
            b1_reg    <= in_right;
            prod1_reg <= in_left * in_right;
            item2_reg <= item2_next;
        end
    end

    always_comb begin
        sum_w    = {a1_reg[q16au_pkg::DATA_W-1], a1_reg} + {b1_reg[q16au_pkg::DATA_W-1], b1_reg};
        sadd_val = sum_w[q16au_pkg::DATA_W-1:0];
        if (sum_w[q16au_pkg::DATA_W] != sum_w[q16au_pkg::DATA_W-1]) begin
            sadd_val = sum_w[q16au_pkg::DATA_W] ? q16au_pkg::MIN_VAL : q16au_pkg::MAX_VAL;
        end

        mul_round = prod1_reg + q16au_pkg::ROUND_HALF;
        mul_shift = mul_round >>> q16au_pkg::FRAC_BITS;
        if (mul_shift > q16au_pkg::MAX_WIDE) begin
            mul_val = q16au_pkg::MAX_VAL;
        end else if (mul_shift < q16au_pkg::MIN_WIDE) begin
            mul_val = q16au_pkg::MIN_VAL;
        end else begin
            mul_val = mul_shift[q16au_pkg::DATA_W-1:0];
        end

        abs_a  = a1_reg[q16au_pkg::DATA_W-1] ? (~a1_reg + 1'b1) : a1_reg;
        abs_b  = b1_reg[q16au_pkg::DATA_W-1] ? (~b1_reg + 1'b1) : b1_reg;
        b_zero = (b1_reg == '0);

        item2_next.is_div  = 1'b0;
        item2_next.neg     = a1_reg[q16au_pkg::DATA_W-1] ^ b1_reg[q16au_pkg::DATA_W-1];
        item2_next.dz      = 1'b0;
        item2_next.result  = '0;
        item2_next.divisor = abs_b;
        item2_next.rem     = '0;
        item2_next.num     = {abs_a, {q16au_pkg::FRAC_BITS{1'b0}}}
                           + q16au_pkg::DIV_W'(abs_b >> 1);

        case (q16au_pkg::action_t'(op1_reg))
            q16au_pkg::ACT_ADD:  item2_next.result = a1_reg + b1_reg;
            q16au_pkg::ACT_SADD: item2_next.result = sadd_val;
            q16au_pkg::ACT_SUB:  item2_next.result = a1_reg - b1_reg;
            q16au_pkg::ACT_MUL:  item2_next.result = mul_val;
            q16au_pkg::ACT_DIV: begin
                item2_next.is_div = !b_zero;
                item2_next.dz     = b_zero;
                item2_next.result = a1_reg[q16au_pkg::DATA_W-1] ? q16au_pkg::MIN_VAL
                                                                : q16au_pkg::MAX_VAL;
            end
            default: item2_next.result = '0;
        endcase
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

endmodule

### sv/q16au_div_cell.sv
module q16au_div_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  q16au_pkg::cell_t in_item,
    output logic             out_valid,
    output q16au_pkg::cell_t out_item
);

    logic             valid_reg;
    q16au_pkg::cell_t item_reg;
    q16au_pkg::cell_t item_next;

    logic [q16au_pkg::DATA_W:0] trial;
    logic [q16au_pkg::DATA_W:0] diff;
    logic                       ge;

    always_comb begin
        trial = {in_item.rem, in_item.num[q16au_pkg::DIV_W-1]};
        diff  = trial - {1'b0, in_item.divisor};
        ge    = (trial >= {1'b0, in_item.divisor});

        item_next     = in_item;
        item_next.rem = ge ? diff[q16au_pkg::DATA_W-1:0] : trial[q16au_pkg::DATA_W-1:0];
        item_next.num = {in_item.num[q16au_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### sv/q16au_out.sv
module q16au_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  q16au_pkg::cell_t                    in_item,
    output logic                                adv,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [q16au_pkg::DATA_W-1:0] m_result_value,
    output logic                                m_divide_by_zero
);

    logic                          main_valid_reg;
    logic [q16au_pkg::DATA_W-1:0]  main_val_reg;
    logic                          main_dz_reg;
    logic                          spare_valid_reg;
    logic [q16au_pkg::DATA_W-1:0]  spare_val_reg;
    logic                          spare_dz_reg;

    logic [q16au_pkg::DATA_W-1:0]  quot;
    logic [q16au_pkg::DATA_W-1:0]  final_val;
    logic                          incoming;

    always_comb begin
        quot      = in_item.num[q16au_pkg::DATA_W-1:0];
        final_val = in_item.result;
        if (in_item.is_div) begin
            final_val = in_item.neg ? (~quot + 1'b1) : quot;
        end
    end

    assign adv      = !spare_valid_reg;
    assign incoming = in_valid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_ready) begin
            if (spare_valid_reg) begin
                main_valid_reg  <= 1'b1;
                spare_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= incoming;
            end
        end else if (incoming) begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            if (spare_valid_reg) begin
                main_val_reg <= spare_val_reg;
                main_dz_reg  <= spare_dz_reg;
            end else begin
                main_val_reg <= final_val;
                main_dz_reg  <= in_item.dz;
            end
        end else if (incoming) begin
            spare_val_reg <= final_val;
            spare_dz_reg  <= in_item.dz;
        end
    end

    assign m_valid          = main_valid_reg;
    assign m_result_value   = main_val_reg;
    assign m_divide_by_zero = main_dz_reg;

endmodule

### sv/q16_16_arithmetic_unit.sv
// Signed Q16.16 arithmetic unit: wrapping add, saturating add, wrapping subtract,
// rounding saturating multiply and rounding divide, one result per item. It takes
// a new item every cycle while s_ready is high and returns results in order; each
// item passes the front registers and then the divide chain of DATA_W + FRAC_BITS
// restoring-division cells (48 for Q16.16), one quotient bit per cell, which
// every operation passes through. An output register with one spare entry keeps
// the input side running while a result waits; s_ready drops only while that
// spare entry is occupied. A zero divisor yields the maximum or minimum value by
// the dividend's sign with m_divide_by_zero set; unused action codes yield zero.
module q16_16_arithmetic_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_action,
    input  logic signed [q16au_pkg::DATA_W-1:0] s_left_operand,
    input  logic signed [q16au_pkg::DATA_W-1:0] s_right_operand,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [q16au_pkg::DATA_W-1:0] m_result_value,
    output logic                                m_divide_by_zero
);

    logic                       adv;
    logic [q16au_pkg::DIV_W:0]  chain_valid;
    q16au_pkg::cell_t           chain_item [0:q16au_pkg::DIV_W];

    assign s_ready = adv;

    q16au_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_action (s_action),
        .in_left   (s_left_operand),
        .in_right  (s_right_operand),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0])
    );

    for (genvar i = 0; i < q16au_pkg::DIV_W; i++) begin : g_cell
        q16au_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    q16au_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (chain_valid[q16au_pkg::DIV_W]),
        .in_item          (chain_item[q16au_pkg::DIV_W]),
        .adv              (adv),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_value   (m_result_value),
        .m_divide_by_zero (m_divide_by_zero)
    );

endmodule

### sv/q16au_checker.sv
`include "q16_16_arithmetic_unit_defines.svh"

module q16au_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [q16au_pkg::DATA_W-1:0] m_result_value,
    input logic                                m_divide_by_zero
);

    `Q16AU_ASSERT_NOW(a_dz_saturates, aclk, aresetn, m_valid && m_divide_by_zero,
        m_result_value == $signed(q16au_pkg::MAX_VAL) ||
        m_result_value == $signed(q16au_pkg::MIN_VAL))

    `Q16AU_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready,
        $past(m_valid && !m_ready))

    `Q16AU_ASSERT_NEXT(a_ready_holds, aclk, aresetn, s_ready && (m_ready || !m_valid),
        s_ready)

    `Q16AU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_result_value) && $stable(m_divide_by_zero))

endmodule

bind q16_16_arithmetic_unit q16au_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_value   (m_result_value),
    .m_divide_by_zero (m_divide_by_zero)
);
